[rtl/tup_pkg.sv]
// ----------------------------------------------------------------------------
// tup_pkg: shared types and constants
// Request codes, register indexes, fixed-point widths, palette function.
// ----------------------------------------------------------------------------
package tup_pkg;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_RENDER = 1'b1;

  localparam logic [0:0] REG_X_STEP = 1'b0;
  localparam logic [0:0] REG_Y_STEP = 1'b1;

  localparam int FRAC_BITS = 20;
  localparam int STEP_W    = 24;
  localparam int COORD_W   = 10;
  localparam int POS_W     = STEP_W + COORD_W;
  localparam int SAMPLE_W  = 16;

  localparam logic [STEP_W-1:0]   X_STEP_RST = 24'd101899;
  localparam logic [STEP_W-1:0]   Y_STEP_RST = 24'd100909;
  localparam logic signed [15:0]  MIN_RST    = 16'sd32767;
  localparam logic signed [15:0]  MAX_RST    = 16'sd0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // gray 0..255 to byte-swapped RGB565
  function automatic logic [15:0] palette(input logic [7:0] g);
    logic [4:0]  r;
    logic [5:0]  gr;
    logic [4:0]  b;
    logic [15:0] raw;
    logic [11:0] t;
    r  = '0;
    gr = '0;
    b  = '0;
    t  = '0;
    case (g[7:6])
      2'd0: begin
        t = {4'd0, g} * 12'd31;
        b = t[10:6];
      end
      2'd1: begin
        t  = {6'd0, g[5:0]} * 12'd63;
        gr = t[11:6];
        t  = {6'd0, ~g[5:0]} * 12'd31;
        b  = t[10:6];
      end
      2'd2: begin
        t  = {6'd0, g[5:0]} * 12'd31;
        r  = t[10:6];
        gr = 6'd63;
      end
      default: begin
        r  = 5'd31;
        t  = {6'd0, ~g[5:0]} * 12'd63;
        gr = t[11:6];
      end
    endcase
    raw = {r, gr, b};
    return {raw[7:0], raw[15:8]};
  endfunction

endpackage

[rtl/tup_ram.sv]
// ----------------------------------------------------------------------------
// tup_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module tup_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/tup_norm.sv]
// ----------------------------------------------------------------------------
// tup_norm: normalizer
// gray = (v-min)*255/(max-min), saturated, by restoring division (1 bit/cycle).
// ----------------------------------------------------------------------------
module tup_norm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [16:0]    value,
  input  tup_pkg::sample_t      fmin,
  input  tup_pkg::sample_t      fmax,
  output logic                  done,
  output logic [7:0]            gray
);
  import tup_pkg::*;

  // num*255 < 2^25; quotient over 9 bits enough to detect > 255
  localparam int QB = 9;

  logic        busy_r, busy_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [16:0] den_r, den_nxt;
  logic [QB-1:0] q_r, q_nxt;
  logic        zero_r, zero_nxt;
  logic        done_r, done_nxt;

  logic signed [17:0] num;
  logic signed [17:0] den;
  logic [25:0] trial;

  always_comb begin
    num = 18'(value) - 18'(fmin);
    den = 18'(fmax) - 18'(fmin);
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    trial    = rem_r - ({9'd0, den_r} << cnt_r);
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'(QB - 1);
      rem_nxt  = 26'(num[16:0]) * 26'd255;
      den_nxt  = den[16:0];
      q_nxt    = '0;
      zero_nxt = (den <= 0) || (num <= 0);
    end else if (busy_r) begin
      if (rem_r >= ({9'd0, den_r} << cnt_r)) begin
        rem_nxt      = trial;
        q_nxt[cnt_r] = 1'b1;
      end
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    zero_r <= zero_nxt;
  end

  assign done = done_r;
  assign gray = zero_r ? 8'd0 : (q_r[8] ? 8'd255 : q_r[7:0]);
endmodule

[rtl/thermal_upscale_pseudocolor.sv]
// ----------------------------------------------------------------------------
// thermal_upscale_pseudocolor: bilinear upscaler with four-band palette
// Loads sensor samples into a RAM, renders pixels by bilinear interpolation,
// normalization to 0..255 and RGB565 palette lookup (bytes swapped).
//
//  channel | dir | beat
//  in_     | in  | load one sample or render one pixel
//  out_    | out | one pixel_word per render
//  cfg_    | in  | write x_step (index 0) or y_step (index 1)
//
// Load: RAM write and min/max update at the accepting edge.
// Render, from accept to out_valid: position multiply, four sequential
// RAM reads on one port, product drain, sum, 9-step serial divide plus
// done, palette. Past the table edge the reads and drain are skipped.
// Reset clears control, presets min/max and steps; sample RAM stays undefined.
// A finished pixel sits in the output register; the next input is taken
// while it waits, but a second render stalls until it is taken.
// ----------------------------------------------------------------------------
module thermal_upscale_pseudocolor #(
  parameter int SENSOR_COLS = 32,
  parameter int SENSOR_ROWS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_req_type,
  input  logic [4:0]              in_sample_col,
  input  logic [4:0]              in_sample_row,
  input  logic signed [15:0]      in_sample_value,
  input  logic                    in_frame_start,
  input  logic [9:0]              in_out_x,
  input  logic [9:0]              in_out_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             out_pixel_word,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [0:0]              cfg_index,
  input  logic [23:0]             cfg_data
);
  import tup_pkg::*;

  localparam int DEPTH = SENSOR_COLS * SENSOR_ROWS;
  localparam int AW    = $clog2(DEPTH);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_POS  = 4'd1;  // positions registered
  localparam logic [3:0] S_RD   = 4'd2;  // issue neighbour reads
  localparam logic [3:0] S_MUL  = 4'd3;  // last product accumulate
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_NORM = 4'd5;
  localparam logic [3:0] S_OUT  = 4'd6;

  logic [3:0]  state_r, state_nxt;
  logic [23:0] x_step_r, y_step_r;
  sample_t     fmax_r, fmin_r;

  logic [POS_W-1:0] px_r, py_r;
  logic [2:0]  rd_r, rd_nxt;     // read issue counter
  logic        rv_r;             // read data valid on ram_rdata
  logic [1:0]  rk_r;             // which neighbour rdata belongs to
  logic        edge_r;
  logic signed [SAMPLE_W-1:0] smp_r;
  logic        sv_r;
  logic [40:0] w_r;
  logic signed [57:0] acc_r;
  logic signed [16:0] val;

  logic        out_valid_r;
  logic [15:0] out_word_r;

  // RAM port
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [15:0]     ram_rdata;

  tup_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_sample_value),
    .rdata(ram_rdata)
  );

  logic load_ok;
  logic in_fire;
  assign load_ok = ({27'd0, in_sample_col} < 32'(SENSOR_COLS)) &&
                   ({27'd0, in_sample_row} < 32'(SENSOR_ROWS));
  // render needs the output register free once it finishes
  assign in_ready  = (state_r == S_IDLE) &&
                     !(in_req_type == REQ_RENDER && out_valid_r);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = (state_r == S_IDLE);

  // integer parts and fractions
  logic [POS_W-FRAC_BITS-1:0] ci, ri;
  logic [FRAC_BITS-1:0]       fx, fy;
  logic [FRAC_BITS:0]         wx0, wy0, wxa, wya;
  assign ci  = px_r[POS_W-1:FRAC_BITS];
  assign ri  = py_r[POS_W-1:FRAC_BITS];
  assign fx  = px_r[FRAC_BITS-1:0];
  assign fy  = py_r[FRAC_BITS-1:0];
  assign wx0 = 21'h100000 - {1'b0, fx};
  assign wy0 = 21'h100000 - {1'b0, fy};

  // neighbour k: bit0 = +col, bit1 = +row
  logic [1:0]  rk_sel;
  logic [AW-1:0] rd_addr;
  assign rk_sel = rd_r[1:0];
  always_comb begin
    logic [31:0] a;
    a = (32'(ri) + 32'(rk_sel[1])) * 32'(SENSOR_COLS) + 32'(ci) + 32'(rk_sel[0]);
    rd_addr = a[AW-1:0];
  end

  // weight factors for the neighbour whose data is on ram_rdata
  always_comb begin
    wxa = rk_r[0] ? {1'b0, fx} : wx0;
    wya = rk_r[1] ? {1'b0, fy} : wy0;
  end

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = rd_addr;
    if (in_fire && in_req_type == REQ_LOAD && load_ok) begin
      ram_we = 1'b1;
      ram_addr = AW'((32'(SENSOR_ROWS) - 32'd1 - 32'(in_sample_row)) *
                     32'(SENSOR_COLS) + 32'(in_sample_col));
    end
  end

  // interpolated value, floor of acc / 2^40; final while in S_SUM
  assign val = edge_r ? 17'sd0 : 17'(acc_r >>> 40);

  logic norm_start, norm_done;
  logic [7:0] gray;
  tup_norm u_norm (
    .clk  (clk),
    .rst_n(rst_n),
    .start(norm_start),
    .value(val),
    .fmin (fmin_r),
    .fmax (fmax_r),
    .done (norm_done),
    .gray (gray)
  );
  assign norm_start = (state_r == S_SUM);

  always_comb begin
    state_nxt = state_r;
    rd_nxt    = rd_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_req_type == REQ_RENDER) begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        rd_nxt    = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (edge_r) begin
          state_nxt = S_SUM;
        end else if (rd_r == 3'd4) begin
          state_nxt = S_MUL;
        end else begin
          rd_nxt = rd_r + 3'd1;
        end
      end
      S_MUL: begin
        // drain: sample and weight -> accumulate
        if (!rv_r && !sv_r) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM:  state_nxt = S_NORM;
      S_NORM: begin
        if (norm_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_step_r    <= X_STEP_RST;
      y_step_r    <= Y_STEP_RST;
      fmax_r      <= MAX_RST;
      fmin_r      <= MIN_RST;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
      sv_r        <= 1'b0;
      rd_r        <= '0;
    end else begin
      state_r <= state_nxt;
      rd_r    <= rd_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_X_STEP) begin
          x_step_r <= cfg_data;
        end else begin
          y_step_r <= cfg_data;
        end
      end
      if (in_fire && in_req_type == REQ_LOAD) begin
        if (load_ok) begin
          if (in_frame_start) begin
            fmax_r <= (in_sample_value > MAX_RST) ? in_sample_value : MAX_RST;
            fmin_r <= (in_sample_value < MIN_RST) ? in_sample_value : MIN_RST;
          end else begin
            if (in_sample_value > fmax_r) fmax_r <= in_sample_value;
            if (in_sample_value < fmin_r) fmin_r <= in_sample_value;
          end
        end else if (in_frame_start) begin
          fmax_r <= MAX_RST;
          fmin_r <= MIN_RST;
        end
      end
      // read issue: four beats from S_RD with rd_r 0..3
      rv_r <= (state_r == S_RD) && !edge_r && (rd_r < 3'd4);
      sv_r <= rv_r;
      if (state_r == S_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire && in_req_type == REQ_RENDER) begin
      px_r <= POS_W'(in_out_x) * POS_W'(x_step_r);
      py_r <= POS_W'(in_out_y) * POS_W'(y_step_r);
    end
    if (state_r == S_POS) begin
      edge_r <= (32'(ci) > 32'(SENSOR_COLS - 2)) || (32'(ri) > 32'(SENSOR_ROWS - 2));
      acc_r  <= '0;
    end
    rk_r <= rk_sel;
    // stage 1: sample captured, weight product computed alongside
    smp_r <= ram_rdata;
    w_r   <= 41'(wxa) * 41'(wya);
    // stage 2: sample times weight (16 x 41)
    if (sv_r) begin
      acc_r <= acc_r + 58'(smp_r * $signed({1'b0, w_r}));
    end
    if (state_r == S_OUT) begin
      out_word_r <= palette(gray);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_word = out_word_r;
endmodule
